>>> hdl/mbps_pkg.sv
// shared types and constants for the masked byte pattern scanner
// no dependencies; imported by every module of the block

package mbps_pkg;

  localparam int DEF_MAX_PATTERN_BYTES = 32;
  localparam int DEF_OFFSET_BITS       = 32;

  // pattern register file holds 32 bytes
  localparam int PATTERN_REG_BYTES = 32;
  localparam int PATTERN_BITS      = PATTERN_REG_BYTES * 8;
  localparam int LEN_W             = 6;
  localparam int OCC_W             = 16;
  localparam int OUT_OFFSET_W      = 32;
  localparam int CFG_INDEX_W       = 3;
  localparam int CFG_DATA_W        = 64;

  // queue between the compare front and the counting back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_0     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_1     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_2     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_3     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_OCC    = 3'd6;

  // one classified byte, as handed from front to back
  typedef struct packed {
    logic                    hit;
    logic                    last;
    logic [OUT_OFFSET_W-1:0] start;
  } mbps_item_t;

endpackage

>>> hdl/mbps_front.sv
// front part: accepts bytes, shifts the window and runs the masked compare
// depends on mbps_pkg

module mbps_front #(
  parameter int MAX_PATTERN_BYTES = mbps_pkg::DEF_MAX_PATTERN_BYTES,
  parameter int OFFSET_BITS       = mbps_pkg::DEF_OFFSET_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_last_byte,
  input  logic [mbps_pkg::PATTERN_BITS-1:0] pattern,
  input  logic [31:0]                     care_mask,
  input  logic [mbps_pkg::LEN_W-1:0]      pattern_length,
  input  logic [mbps_pkg::QCNT_W-1:0]     queue_count,
  output logic                            push_valid,
  output mbps_pkg::mbps_item_t            push_item
);
  import mbps_pkg::*;

  localparam int CMP_BYTES = (PATTERN_REG_BYTES < MAX_PATTERN_BYTES) ?
                             PATTERN_REG_BYTES : MAX_PATTERN_BYTES;
  localparam int FILL_W    = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int CW        = (FILL_W > LEN_W) ? FILL_W : LEN_W;
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_PATTERN_BYTES);
  localparam logic [LEN_W-1:0]  LEN_CAP  = LEN_W'(CMP_BYTES);

  logic [7:0]             win_r [MAX_PATTERN_BYTES];
  logic [FILL_W-1:0]      fill_r, fill_inc;
  logic [OFFSET_BITS-1:0] pos_r;

  logic                   s1_valid_r;
  logic                   s1_last_r;
  logic [FILL_W-1:0]      s1_fill_r;
  logic [OFFSET_BITS-1:0] s1_pos_r;

  // pattern aligned to the newest window byte, refreshed every cycle
  logic [7:0]             al_pat_r  [CMP_BYTES];
  logic [CMP_BYTES-1:0]   al_care_r;
  logic [LEN_W-1:0]       len_r;
  logic [LEN_W-1:0]       len_eff;

  logic                   accept;
  logic [CMP_BYTES-1:0]   miss;
  logic                   win_ok;
  logic [OFFSET_BITS-1:0] start;
  logic [OFFSET_BITS+OUT_OFFSET_W-1:0] start_ext;

  assign accept   = in_valid && in_ready;
  assign in_ready = ((QCNT_W+1)'(queue_count) + (QCNT_W+1)'(s1_valid_r))
                    < (QCNT_W+1)'(QUEUE_DEPTH);
  assign fill_inc = (fill_r == FILL_MAX) ? fill_r : fill_r + 1'b1;

  always_comb begin
    len_eff = pattern_length;
    if (len_eff == '0) begin
      len_eff = LEN_W'(1);
    end
    if (len_eff > LEN_CAP) begin
      len_eff = LEN_CAP;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < CMP_BYTES; j++) begin
      logic [LEN_W-1:0] k;
      k = len_eff - LEN_W'(1) - LEN_W'(j);
      al_pat_r[j]  <= pattern[{k[4:0], 3'b000} +: 8];
      al_care_r[j] <= (LEN_W'(j) < len_eff) && care_mask[k[4:0]];
    end
    len_r <= len_eff;
  end

  // byte window and section counters
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[MAX_PATTERN_BYTES-1] <= in_data_byte;
      s1_last_r <= in_last_byte;
      s1_fill_r <= fill_inc;
      s1_pos_r  <= pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      pos_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (accept) begin
        if (in_last_byte) begin
          fill_r <= '0;
          pos_r  <= '0;
        end else begin
          fill_r <= fill_inc;
          pos_r  <= pos_r + 1'b1;
        end
      end
    end
  end

  // masked compare of the newest bytes
  always_comb begin
    for (int j = 0; j < CMP_BYTES; j++) begin
      miss[j] = al_care_r[j] && (win_r[MAX_PATTERN_BYTES-1-j] != al_pat_r[j]);
    end
  end

  assign win_ok    = (CW'(s1_fill_r) >= CW'(len_r)) && (miss == '0);
  assign start     = s1_pos_r + OFFSET_BITS'(1) - OFFSET_BITS'(len_r);
  assign start_ext = {{OUT_OFFSET_W{1'b0}}, start};

  assign push_valid      = s1_valid_r;
  assign push_item.hit   = win_ok;
  assign push_item.last  = s1_last_r;
  assign push_item.start = start_ext[OUT_OFFSET_W-1:0];

endmodule

>>> hdl/mbps_queue.sv
// short queue of classified bytes between front and back
// depends on mbps_pkg

module mbps_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  mbps_pkg::mbps_item_t        push_item,
  input  logic                        pop,
  output logic                        not_empty,
  output mbps_pkg::mbps_item_t        head,
  output logic [mbps_pkg::QCNT_W-1:0] count
);
  import mbps_pkg::*;

  mbps_item_t        slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> hdl/mbps_back.sv
// back part: counts matches, decides found or not-found, holds the result
// depends on mbps_pkg

module mbps_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                not_empty,
  input  mbps_pkg::mbps_item_t                head,
  output logic                                pop,
  input  logic [mbps_pkg::OCC_W-1:0]          target_occurrence,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_found,
  output logic [mbps_pkg::OUT_OFFSET_W-1:0]   out_match_offset
);
  import mbps_pkg::*;

  logic [OCC_W-1:0]        seen_r, seen_nxt;
  logic                    rep_r, rep_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    found_r;
  logic [OUT_OFFSET_W-1:0] offset_r;
  logic                    hit, emit_found, emit_none;

  assign pop        = not_empty && (!out_valid_r || out_ready);
  assign hit        = !rep_r && head.hit;
  assign emit_found = hit && (seen_r == target_occurrence);
  assign emit_none  = head.last && !rep_r && !emit_found;

  always_comb begin
    seen_nxt      = seen_r;
    rep_nxt       = rep_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (pop) begin
      if (hit && !emit_found && (seen_r != {OCC_W{1'b1}})) begin
        seen_nxt = seen_r + 1'b1;
      end
      rep_nxt = rep_r || emit_found;
      if (head.last) begin
        seen_nxt = '0;
        rep_nxt  = 1'b0;
      end
      if (emit_found || emit_none) begin
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (emit_found || emit_none)) begin
      found_r  <= emit_found;
      offset_r <= emit_found ? head.start : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      rep_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seen_r      <= seen_nxt;
      rep_r       <= rep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = found_r;
  assign out_match_offset = offset_r;

endmodule

>>> hdl/masked_byte_pattern_scan.sv
// top level of the masked byte pattern scanner: config registers and wiring
// depends on mbps_pkg, mbps_front, mbps_queue, mbps_back
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, in_data_byte, in_last_byte | sink
//  out     | out_valid/out_ready, out_found, out_match_offset | source
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | sink
//
// one byte per cycle sustained while the output keeps up; the window shifts at
// the byte's transfer edge, the compare result enters the queue at the next
// edge, and the result register loads when the back pops the deciding entry,
// which output stalls and older queued entries can delay; the queue absorbs
// output stalls, and in_ready drops only once the queue and compare stage hold
// QUEUE_DEPTH bytes; reset is synchronous and no clearing pass is needed
// cfg_ready is always high and writes are registered; the aligned compare copy
// of pattern and length is registered from them at the following edge

module masked_byte_pattern_scan #(
  parameter int MAX_PATTERN_BYTES = mbps_pkg::DEF_MAX_PATTERN_BYTES,
  parameter int OFFSET_BITS       = mbps_pkg::DEF_OFFSET_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_data_byte,
  input  logic                                in_last_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_found,
  output logic [mbps_pkg::OUT_OFFSET_W-1:0]   out_match_offset,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mbps_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mbps_pkg::*;

  // configuration registers
  logic [PATTERN_BITS-1:0] pattern_r;
  logic [31:0]             care_r;
  logic [LEN_W-1:0]        len_r;
  logic [OCC_W-1:0]        target_r;

  // front to queue to back
  logic                    push_valid;
  mbps_item_t              push_item;
  logic                    q_not_empty;
  mbps_item_t              q_head;
  logic [QCNT_W-1:0]       q_count;
  logic                    q_pop;

  assign cfg_ready = 1'b1;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      care_r    <= '1;
      len_r     <= LEN_W'(1);
      target_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_0:   pattern_r[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
        REG_PATTERN_1:   pattern_r[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
        REG_PATTERN_2:   pattern_r[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
        REG_PATTERN_3:   pattern_r[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
        REG_CARE_MASK:   care_r   <= cfg_data[31:0];
        REG_PATTERN_LEN: len_r    <= cfg_data[LEN_W-1:0];
        REG_TARGET_OCC:  target_r <= cfg_data[OCC_W-1:0];
        default: ;
      endcase
    end
  end

  // window shift and masked compare
  mbps_front #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .OFFSET_BITS       (OFFSET_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .pattern        (pattern_r),
    .care_mask      (care_r),
    .pattern_length (len_r),
    .queue_count    (q_count),
    .push_valid     (push_valid),
    .push_item      (push_item)
  );

  // decouples compare from result stalls
  mbps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_item (push_item),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head),
    .count     (q_count)
  );

  // occurrence counting and result register
  mbps_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .not_empty         (q_not_empty),
    .head              (q_head),
    .pop               (q_pop),
    .target_occurrence (target_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_match_offset  (out_match_offset)
  );

endmodule
